// ===== rtl/core/srd_pkg.sv =====
// Shared types and constants for the stationary run detector.
// Used by every module in rtl/core; no dependencies of its own.
package srd_pkg;

  // Field widths
  localparam int COORD_BITS     = 24;
  localparam int INDEX_BITS     = 20;
  localparam int THR_BITS       = 24;
  localparam int MIN_BITS       = 20;
  localparam int TAG_BITS       = 16;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 2;

  // Arithmetic widths
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int THR2_BITS = 2 * THR_BITS;

  // Queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Result queue
  localparam int RES_DEPTH    = 2;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  // Register reset values
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(256);
  localparam logic [MIN_BITS-1:0] MIN_RESET = MIN_BITS'(3);
  localparam logic [TAG_BITS-1:0] TAG_RESET = TAG_BITS'(0);

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MOVE_THRESHOLD  = 2'd0,
    REG_MIN_RUN_SAMPLES = 2'd1,
    REG_TAG_VALUE       = 2'd2
  } cfg_reg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic still;
    logic last;
  } class_item_t;

  // One reported run
  typedef struct packed {
    logic [INDEX_BITS-1:0] start_index;
    logic [INDEX_BITS-1:0] end_index;
    logic [TAG_BITS-1:0]   tag;
  } result_t;

endpackage

// ===== rtl/core/srd_front.sv =====
// Front end: accepts samples, squares the per-axis steps and classifies
// each sample as still or moving. Depends on srd_pkg.
module srd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [srd_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [srd_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [srd_pkg::COORD_BITS-1:0] pos_z,
  input  logic                          last_sample,
  input  logic [srd_pkg::THR_BITS-1:0]  move_threshold,
  input  logic [srd_pkg::QUEUE_CNT_BITS-1:0] queue_count,
  output logic                          q_push,
  output srd_pkg::class_item_t          q_item
);
  import srd_pkg::*;

  localparam int OCC_BITS = QUEUE_CNT_BITS + 1;

  logic accept;

  // Previous sample
  logic [COORD_BITS-1:0] prev_x, prev_y, prev_z;
  logic                  have_previous;

  // Stage 1: step magnitudes
  logic                  v1;
  logic                  last1;
  logic [COORD_BITS-1:0] dx1, dy1, dz1;

  // Stage 2: squares
  logic                  v2;
  logic                  last2;
  logic [SQ_BITS-1:0]    sx2, sy2, sz2;
  logic [THR2_BITS-1:0]  thr2;

  logic [OCC_BITS-1:0]   occupancy;
  logic [SUM_BITS-1:0]   dist2;

  function automatic logic [COORD_BITS-1:0] step_mag(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] m;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m = d[COORD_BITS] ? (~d + 1'b1) : d;
    return m[COORD_BITS-1:0];
  endfunction

  // Credit check: queue slots plus samples still in flight
  assign occupancy = OCC_BITS'(queue_count) + OCC_BITS'(v1) + OCC_BITS'(v2);
  assign full      = (occupancy >= OCC_BITS'(QUEUE_DEPTH));
  assign accept    = push && !full;

  // Previous sample, cleared after the final sample of a sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      have_previous <= 1'b0;
    end else if (accept) begin
      if (last_sample) begin
        prev_x        <= '0;
        prev_y        <= '0;
        prev_z        <= '0;
        have_previous <= 1'b0;
      end else begin
        prev_x        <= pos_x;
        prev_y        <= pos_y;
        prev_z        <= pos_z;
        have_previous <= 1'b1;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Stage 1 payload; first sample counts as zero step
  always_ff @(posedge clk) begin
    if (accept) begin
      last1 <= last_sample;
      dx1   <= have_previous ? step_mag(pos_x, prev_x) : '0;
      dy1   <= have_previous ? step_mag(pos_y, prev_y) : '0;
      dz1   <= have_previous ? step_mag(pos_z, prev_z) : '0;
    end
  end

  // Stage 2 payload: one multiplier per axis plus threshold square
  always_ff @(posedge clk) begin
    if (v1) begin
      last2 <= last1;
      sx2   <= SQ_BITS'(dx1) * SQ_BITS'(dx1);
      sy2   <= SQ_BITS'(dy1) * SQ_BITS'(dy1);
      sz2   <= SQ_BITS'(dz1) * SQ_BITS'(dz1);
      thr2  <= THR2_BITS'(move_threshold) * THR2_BITS'(move_threshold);
    end
  end

  // Sum and compare into the queue
  assign dist2        = SUM_BITS'(sx2) + SUM_BITS'(sy2) + SUM_BITS'(sz2);
  assign q_push       = v2;
  assign q_item.still = (dist2 <= SUM_BITS'(thr2));
  assign q_item.last  = last2;

  // Credit never overcommits the queue
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_BITS'(QUEUE_DEPTH))
    else $error("front: queue credit overcommitted");

  // Stage 2 follows stage 1 in the next cycle
  a_pipe_follow: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2)
    else $error("front: sample lost between stages");

endmodule

// ===== rtl/core/srd_queue.sv =====
// Short queue of classified samples between front and back.
// Depends on srd_pkg.
module srd_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  srd_pkg::class_item_t               push_item,
  input  logic                               pop,
  output logic                               valid,
  output srd_pkg::class_item_t               head_item,
  output logic [srd_pkg::QUEUE_CNT_BITS-1:0] count
);
  import srd_pkg::*;

  class_item_t               entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic                      do_pop;

  assign valid     = (count != '0);
  assign do_pop    = pop && valid;
  assign head_item = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // Front credit must keep a full queue from being written
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == QUEUE_CNT_BITS'(QUEUE_DEPTH)) |-> !push)
    else $error("queue: push while full");

endmodule

// ===== rtl/core/srd_back.sv =====
// Back end: tracks the current stationary run, reports qualifying runs
// into a small result queue. Depends on srd_pkg.
module srd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  srd_pkg::class_item_t           q_item,
  output logic                           q_pop,
  input  logic [srd_pkg::MIN_BITS-1:0]   min_run_samples,
  input  logic [srd_pkg::TAG_BITS-1:0]   tag_value,
  output logic                           empty,
  input  logic                           pop,
  output logic [srd_pkg::INDEX_BITS-1:0] run_start_index,
  output logic [srd_pkg::INDEX_BITS-1:0] run_end_index,
  output logic [srd_pkg::TAG_BITS-1:0]   run_tag
);
  import srd_pkg::*;

  // Run state
  logic                  in_stationary_run;
  logic [INDEX_BITS-1:0] start_index, end_index, sample_counter;

  logic                  in_run_mid;
  logic [INDEX_BITS-1:0] start_mid, end_mid, run_len;
  logic                  close_run, emit;

  // Result queue
  result_t                 res_entries [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] res_wr, res_rd;
  logic [RES_CNT_BITS-1:0] res_count;
  logic                    res_pop;
  result_t                 res_head;

  // Take a sample only with room for its possible result
  assign q_pop = q_valid && (res_count < RES_CNT_BITS'(RES_DEPTH));

  // Stationary sample opens or extends the run
  assign in_run_mid = q_item.still || in_stationary_run;
  assign start_mid  = (q_item.still && !in_stationary_run) ? sample_counter : start_index;
  assign end_mid    = q_item.still ? sample_counter : end_index;
  assign run_len    = end_mid - start_mid;
  assign close_run  = !q_item.still || q_item.last;
  assign emit       = q_pop && close_run && in_run_mid
                      && (run_len >= INDEX_BITS'(min_run_samples));

  // Run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_stationary_run <= 1'b1;
      start_index       <= '0;
      end_index         <= '0;
      sample_counter    <= '0;
    end else if (q_pop) begin
      if (q_item.last) begin
        in_stationary_run <= 1'b1;
        start_index       <= '0;
        end_index         <= '0;
        sample_counter    <= '0;
      end else begin
        in_stationary_run <= in_run_mid && !close_run;
        start_index       <= start_mid;
        end_index         <= end_mid;
        if (sample_counter != INDEX_MAX) sample_counter <= sample_counter + 1'b1;
      end
    end
  end

  // Result queue control
  assign empty    = (res_count == '0);
  assign res_pop  = pop && !empty;
  assign res_head = res_entries[res_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (emit) res_wr <= res_wr + 1'b1;
      if (res_pop) res_rd <= res_rd + 1'b1;
      if (emit && !res_pop) begin
        res_count <= res_count + 1'b1;
      end else if (!emit && res_pop) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_entries[res_wr] <= '{start_index: start_mid, end_index: end_mid, tag: tag_value};
    end
  end

  assign run_start_index = res_head.start_index;
  assign run_end_index   = res_head.end_index;
  assign run_tag         = res_head.tag;

  // Indices only grow within a sequence
  a_start_le_end: assert property (@(posedge clk) disable iff (rst)
    start_index <= end_index)
    else $error("back: run start beyond run end");

  // A final sample returns the index to zero
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.last) |=> (sample_counter == '0) && in_stationary_run)
    else $error("back: state not cleared after final sample");

  // Result queue never overflows
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CNT_BITS'(RES_DEPTH))
    else $error("back: result queue overflow");

endmodule

// ===== rtl/core/stationary_run_detector.sv =====
// Stationary run detector: a sample is accepted per cycle while results are
// popped; a full result queue stalls the run tracker and then raises full.
// A reported run reaches the result ports through the 2 arithmetic stages,
// the sample queue and the result queue, with the run tracker in between.
// Reset (rst, synchronous, active high) restores register defaults and
// clears all queues and run state; no clearing pass is needed.
module stationary_run_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [srd_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [srd_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [srd_pkg::COORD_BITS-1:0] pos_z,
  input  logic                                  last_sample,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [srd_pkg::INDEX_BITS-1:0]        run_start_index,
  output logic [srd_pkg::INDEX_BITS-1:0]        run_end_index,
  output logic [srd_pkg::TAG_BITS-1:0]          run_tag,
  input  logic                                  cfg_write,
  input  logic [srd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [srd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import srd_pkg::*;

  logic [THR_BITS-1:0] move_threshold;
  logic [MIN_BITS-1:0] min_run_samples;
  logic [TAG_BITS-1:0] tag_value;

  logic                      fq_push, bq_pop, bq_valid;
  class_item_t               fq_item, bq_item;
  logic [QUEUE_CNT_BITS-1:0] q_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold  <= THR_RESET;
      min_run_samples <= MIN_RESET;
      tag_value       <= TAG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOVE_THRESHOLD:  move_threshold  <= cfg_data[THR_BITS-1:0];
        REG_MIN_RUN_SAMPLES: min_run_samples <= cfg_data[MIN_BITS-1:0];
        REG_TAG_VALUE:       tag_value       <= cfg_data[TAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  srd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .last_sample    (last_sample),
    .move_threshold (move_threshold),
    .queue_count    (q_count),
    .q_push         (fq_push),
    .q_item         (fq_item)
  );

  srd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_item (fq_item),
    .pop       (bq_pop),
    .valid     (bq_valid),
    .head_item (bq_item),
    .count     (q_count)
  );

  srd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (bq_valid),
    .q_item          (bq_item),
    .q_pop           (bq_pop),
    .min_run_samples (min_run_samples),
    .tag_value       (tag_value),
    .empty           (empty),
    .pop             (pop),
    .run_start_index (run_start_index),
    .run_end_index   (run_end_index),
    .run_tag         (run_tag)
  );

endmodule

// ===== tb/stationary_run_detector_tb.sv =====
// Self-checking testbench for stationary_run_detector: samples go in through a queue port,
// reported runs are checked against an in-bench run predictor as they are popped.
// Depends on srd_pkg and the RTL under rtl/core.
module stationary_run_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  localparam int     SETTLE_CYCLES = 8;     // pipeline flush margin
  localparam int     HOLD_CYCLES   = 300;   // long result-side hold-off
  localparam int     PHASE_ITEMS   = 155;
  localparam int     REPORT_LIMIT  = 100;   // mismatch lines printed, all are counted
  localparam longint TIMEOUT_NS    = 1_000_000;

  // Sample as queued for the driver
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         last;
    logic                         drain;  // hold until every expected run has arrived
  } sample_t;

  // DUT ports, all inputs known from time zero
  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         push        = 1'b0;
  logic                         full;
  logic signed [COORD_BITS-1:0] pos_x       = '0;
  logic signed [COORD_BITS-1:0] pos_y       = '0;
  logic signed [COORD_BITS-1:0] pos_z       = '0;
  logic                         last_sample = 1'b0;
  logic                         empty;
  logic                         pop         = 1'b0;
  logic [INDEX_BITS-1:0]        run_start_index;
  logic [INDEX_BITS-1:0]        run_end_index;
  logic [TAG_BITS-1:0]          run_tag;
  logic                         cfg_write   = 1'b0;
  cfg_reg_t                     cfg_index   = REG_MOVE_THRESHOLD;
  logic [CFG_DATA_BITS-1:0]     cfg_data    = '0;

  // Stimulus and expected runs
  sample_t samples_to_send[$];
  result_t pending_runs[$];
  int      mismatch_count = 0;

  // Handshake bookkeeping, written at the rising edge, read at the falling edge
  bit sent_taken = 1'b0;
  bit res_taken  = 1'b0;

  // Driver and receiver state
  sample_t head;
  bit      fwd_busy     = 1'b0;
  int      gap_left     = 0;
  bit      tx_calm      = 1'b0;
  int      pop_wait     = 0;
  bit      rx_calm      = 1'b0;
  bit      hold_req     = 1'b0;
  bit      hold_started = 1'b0;
  int      hold_left    = 0;

  // Predictor copy of the registers and the run tracker
  logic [THR_BITS-1:0]          thr_cfg;
  logic [MIN_BITS-1:0]          min_len_cfg;
  logic [TAG_BITS-1:0]          tag_cfg;
  logic signed [COORD_BITS-1:0] prior_x, prior_y, prior_z;
  logic                         prior_valid;
  logic                         run_open;
  logic [INDEX_BITS-1:0]        run_first, run_last, sample_idx;

  // Position walk used by the random sequences
  logic signed [COORD_BITS-1:0] walk [3];

  stationary_run_detector i_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .last_sample     (last_sample),
    .empty           (empty),
    .pop             (pop),
    .run_start_index (run_start_index),
    .run_end_index   (run_end_index),
    .run_tag         (run_tag),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Run tracker back to its state after reset
  function automatic void clear_track();
    prior_x     = '0;
    prior_y     = '0;
    prior_z     = '0;
    prior_valid = 1'b0;
    run_open    = 1'b1;
    run_first   = '0;
    run_last    = '0;
    sample_idx  = '0;
  endfunction

  // Advance the tracker by one sample; returns 1 when the sample closes a reportable run
  function automatic bit predict_run(input logic signed [COORD_BITS-1:0] x,
                                     input logic signed [COORD_BITS-1:0] y,
                                     input logic signed [COORD_BITS-1:0] z,
                                     input logic last_flag, output result_t run);
    longint                dx, dy, dz, dist2, thr2;
    logic [INDEX_BITS-1:0] idx, span;
    bit                    still, hit;
    idx   = sample_idx;
    hit   = 1'b0;
    run   = '0;
    dist2 = 0;
    thr2  = longint'(thr_cfg) * longint'(thr_cfg);
    // exact squared distance, no overflow at 24-bit coordinates
    if (prior_valid) begin
      dx    = longint'(x) - longint'(prior_x);
      dy    = longint'(y) - longint'(prior_y);
      dz    = longint'(z) - longint'(prior_z);
      dist2 = dx * dx + dy * dy + dz * dz;
    end
    still = (dist2 <= thr2);
    if (still) begin
      if (!run_open) run_first = idx;
      run_last = idx;
      run_open = 1'b1;
    end
    // motion or end of sequence closes the run
    if (!still || last_flag) begin
      span = run_last - run_first;
      if (run_open && span >= min_len_cfg) begin
        run.start_index = run_first;
        run.end_index   = run_last;
        run.tag         = tag_cfg;
        hit             = 1'b1;
      end
      run_open = 1'b0;
    end
    prior_x     = x;
    prior_y     = y;
    prior_z     = z;
    prior_valid = 1'b1;
    if (sample_idx != INDEX_MAX) sample_idx = sample_idx + 1'b1;
    if (last_flag) clear_track();
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_sample(input logic signed [COORD_BITS-1:0] x,
                                       input logic signed [COORD_BITS-1:0] y,
                                       input logic signed [COORD_BITS-1:0] z,
                                       input logic last, input logic drain);
    sample_t s;
    s.x     = x;
    s.y     = y;
    s.z     = z;
    s.last  = last;
    s.drain = drain;
    samples_to_send.insert(samples_to_send.size(), s);
  endfunction

  // Random sequences shaped around the current threshold: jitter inside it, steps exactly
  // at it and just past it, full-range jumps and single bit flips
  task automatic queue_random_phase(input int count);
    int     kind, axis;
    longint half, step;
    for (int n = 0; n < count; n++) begin
      half = longint'(thr_cfg) / 2;
      kind = $urandom_range(0, 99);
      axis = $urandom_range(0, 2);
      step = longint'(thr_cfg) + ((kind < 55) ? 0 : 1);
      if ($urandom_range(0, 1) == 1) step = -step;
      for (int a = 0; a < 3; a++) begin
        if (kind < 45) begin
          walk[a] = COORD_BITS'(longint'(walk[a]) +
                                (longint'($urandom_range(0, 2 * half)) - half));
        end else if (kind < 65) begin
          if (a == axis) walk[a] = COORD_BITS'(longint'(walk[a]) + step);
        end else if (kind < 90) begin
          walk[a] = COORD_BITS'($urandom);
        end else if (a == axis) begin
          walk[a] = walk[a] ^ COORD_BITS'(1 << $urandom_range(0, COORD_BITS - 1));
        end
      end
      queue_sample(walk[0], walk[1], walk[2], $urandom_range(0, 11) == 0,
                   $urandom_range(0, 149) == 0);
    end
  endtask

  // Everything sent, every expected run transferred, pipeline flushed
  task automatic wait_idle();
    while (samples_to_send.size() != 0 || fwd_busy || pending_runs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers; unused upper data bits carry junk
  task automatic apply_settings(input logic [THR_BITS-1:0] thr,
                                input logic [MIN_BITS-1:0] min_len,
                                input logic [TAG_BITS-1:0] tag);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data  <= thr;
    thr_cfg    = thr;
    @(negedge clk);
    cfg_index  <= REG_MIN_RUN_SAMPLES;
    cfg_data   <= {junk[CFG_DATA_BITS-1:MIN_BITS], min_len};
    min_len_cfg = min_len;
    @(negedge clk);
    cfg_index <= REG_TAG_VALUE;
    cfg_data  <= {junk[CFG_DATA_BITS-1:TAG_BITS], tag};
    tag_cfg    = tag;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Driver: one sample per transfer, random gaps between samples
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (sent_taken) fwd_busy = 1'b0;
      if (!fwd_busy && samples_to_send.size() != 0) begin
        head = samples_to_send[0];
        if (head.drain && pending_runs.size() != 0) begin
          // pause until the result side has caught up
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          head        = samples_to_send.pop_front();
          fwd_busy    = 1'b1;
          pos_x       <= head.x;
          pos_y       <= head.y;
          pos_z       <= head.z;
          last_sample <= head.last;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          gap_left = tx_calm ? 0 : $urandom_range(0, 6);
        end
      end
      push <= fwd_busy;
    end
  end

  // Receiver: random stalls per result, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (res_taken) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        pop_wait = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: check popped runs, predict from accepted samples
  always @(posedge clk) begin
    result_t want, got;
    sent_taken = 1'b0;
    res_taken  = 1'b0;
    if (!rst) begin
      if (pop && !empty) begin
        res_taken = 1'b1;
        if (pending_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected run %0d..%0d tag %0h",
                                    run_start_index, run_end_index, run_tag));
        end else begin
          want = pending_runs.pop_front();
          if (run_start_index !== want.start_index)
            report_mismatch($sformatf("run_start_index %0d, expected %0d",
                                      run_start_index, want.start_index));
          if (run_end_index !== want.end_index)
            report_mismatch($sformatf("run_end_index %0d, expected %0d",
                                      run_end_index, want.end_index));
          if (run_tag !== want.tag)
            report_mismatch($sformatf("run_tag %0h, expected %0h", run_tag, want.tag));
        end
      end
      if (push && !full) begin
        sent_taken = 1'b1;
        if (predict_run(pos_x, pos_y, pos_z, last_sample, got))
          pending_runs.insert(pending_runs.size(), got);
      end
    end
  end

  // Stimulus sequencing and end of test
  initial begin
    thr_cfg     = THR_RESET;
    min_len_cfg = MIN_RESET;
    tag_cfg     = TAG_RESET;
    clear_track();
    for (int a = 0; a < 3; a++) walk[a] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, register defaults: threshold boundary, full-scale coordinate swings,
    // a run closed by motion, a run closed by the last flag, a one-sample sequence.
    // Index saturation needs 2^20 samples in one sequence and is out of reach here.
    queue_sample(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0);
    queue_sample(24'sd256, 24'sd0, 24'sd0, 1'b0, 1'b0);
    queue_sample(24'sd256, 24'sd256, 24'sd0, 1'b0, 1'b0);
    queue_sample(24'sd256, 24'sd256, 24'sd256, 1'b0, 1'b0);
    queue_sample(24'sd513, 24'sd256, 24'sd256, 1'b0, 1'b0);
    queue_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0);
    queue_sample(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    queue_sample(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    queue_sample(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    queue_sample(24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0);
    queue_sample(24'h800000, 24'h800000, 24'h800000, 1'b1, 1'b0);
    queue_sample(-24'sd1, -24'sd1, -24'sd1, 1'b1, 1'b0);

    // Directed, zero threshold and zero minimum: identical samples only, single-sample runs
    apply_settings('0, '0, {TAG_BITS{1'b1}});
    queue_sample(24'sd5, 24'sd5, 24'sd5, 1'b0, 1'b0);
    queue_sample(24'sd5, 24'sd5, 24'sd5, 1'b0, 1'b0);
    queue_sample(24'sd5, 24'sd5, 24'sd6, 1'b0, 1'b0);
    queue_sample(24'sd5, 24'sd5, 24'sd6, 1'b0, 1'b0);
    queue_sample(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0);
    queue_sample(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0);
    queue_sample(24'sd1, 24'sd2, 24'sd3, 1'b1, 1'b0);

    // Random phases, each under its own register setting
    for (int p = 0; p < 13; p++) begin
      case (p)
        0:       apply_settings(THR_BITS'(256), MIN_BITS'(3), TAG_BITS'($urandom));
        1:       apply_settings('0, '0, TAG_BITS'($urandom));
        2:       apply_settings({THR_BITS{1'b1}}, {MIN_BITS{1'b1}}, {TAG_BITS{1'b1}});
        3:       apply_settings({THR_BITS{1'b1}}, '0, '0);
        4:       apply_settings(THR_BITS'(1), MIN_BITS'(1), TAG_BITS'($urandom));
        12:      apply_settings(THR_BITS'($urandom), MIN_BITS'($urandom_range(0, 20)),
                                TAG_BITS'($urandom));
        default: apply_settings(THR_BITS'($urandom_range(0, 4095)),
                                MIN_BITS'($urandom_range(0, 6)), TAG_BITS'($urandom));
      endcase
      // zero threshold and zero minimum report often: hold off pops there to fill the block
      if (p == 1) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      queue_random_phase((p == 2) ? 60 : PHASE_ITEMS);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("stationary_run_detector verification clean");
    end else begin
      $display("stationary_run_detector verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("stationary_run_detector verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/srd_pkg.sv
rtl/core/srd_front.sv
rtl/core/srd_queue.sv
rtl/core/srd_back.sv
rtl/core/stationary_run_detector.sv
tb/stationary_run_detector_tb.sv
